// ===== src/fsg_pkg.sv =====
// Shared types and constants for the frontier successor generator.
// No dependencies; imported by every module of the block.
package fsg_pkg;

  localparam int SLOT_BITS = 5;
  localparam int LOW_BITS  = 64;
  localparam int HIGH_BITS = 61;
  localparam int KEY_BITS  = LOW_BITS + HIGH_BITS;
  localparam int NUM_IDS   = 32;

  // at most this many join successors per key
  localparam logic [3:0] MAX_JOINS = 4'd13;
  localparam logic [4:0] HEIGHT_RESET = 5'd8;

  typedef logic [SLOT_BITS-1:0] slot_t;
  // a colour id before relabeling, one bit wider than a slot
  typedef logic [SLOT_BITS:0]   newid_t;
  typedef logic [KEY_BITS-1:0]  key_t;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_JOIN,
    PH_FRESH
  } phase_t;

endpackage

// ===== src/fsg_relabel.sv =====
// Builds one successor key: shift in a new id, drop the top slot, relabel.
// Depends on fsg_pkg.
module fsg_relabel #(
  parameter int MAX_HEIGHT = 24
) (
  input  fsg_pkg::key_t   key,
  input  fsg_pkg::slot_t  h,
  input  fsg_pkg::newid_t newid,
  output fsg_pkg::key_t   key_out
);
  import fsg_pkg::*;

  localparam int NSLOT = MAX_HEIGHT + 1;

  newid_t           s   [NSLOT];
  slot_t            pc  [NSLOT];
  logic [NSLOT-1:0] first;

  always_comb begin
    for (int k = 0; k < NSLOT; k++) begin
      if (k == 0) begin
        s[k] = newid;
      end else if (5'(k) <= h) begin
        s[k] = {1'b0, key[(k-1)*SLOT_BITS +: SLOT_BITS]};
      end else begin
        s[k] = '0;
      end
    end
    // mark first occurrence of each nonzero id
    for (int k = 0; k < NSLOT; k++) begin
      first[k] = (s[k] != '0);
      for (int j = 0; j < k; j++) begin
        if (s[j] == s[k]) first[k] = 1'b0;
      end
    end
    for (int k = 0; k < NSLOT; k++) begin
      pc[k] = '0;
      for (int j = 0; j <= k; j++) begin
        pc[k] = pc[k] + slot_t'(first[j]);
      end
    end
  end

  always_comb begin
    slot_t lab;
    key_out = '0;
    for (int k = 0; k < NSLOT; k++) begin
      lab = first[k] ? pc[k] : '0;
      for (int j = 0; j < k; j++) begin
        if (first[j] && (s[j] == s[k])) lab = lab | pc[j];
      end
      key_out[k*SLOT_BITS +: SLOT_BITS] = lab;
    end
  end

endmodule

// ===== src/frontier_successor_generator_core.sv =====
// Top level of the frontier successor generator: item register, successor
// sequencer and result register. Depends on fsg_pkg and fsg_relabel.
//
//   channel | direction | handshake         | beat
//   in_     | input     | in_valid/in_stall | one frontier key with row and column flag
//   out_    | output    | out_valid/out_stall | one successor key with its weight
//   cfg_    | input     | cfg_valid/cfg_ready | strip height
//
// A key is decoded as it enters the item register; its successors then leave
// one per cycle through the result register unless out_stall holds them; a
// key has 1 to 15 successors. The next key enters on the cycle its
// predecessor's last successor is registered. out_stall freezes the result
// register and the sequencer while a beat is held; in_stall rises while the
// item register still holds successors. Reset (rst_n low, synchronous)
// empties both registers and sets the height to 8.
module frontier_successor_generator_core #(
  parameter int MAX_HEIGHT = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fsg_pkg::LOW_BITS-1:0]  in_key_low,
  input  logic [fsg_pkg::HIGH_BITS-1:0] in_key_high,
  input  logic [4:0]                    in_row,
  input  logic                          in_past_first_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fsg_pkg::LOW_BITS-1:0]  out_next_key_low,
  output logic [fsg_pkg::HIGH_BITS-1:0] out_next_key_high,
  output logic signed [4:0]             out_weight_constant,
  output logic                          out_weight_q,
  output logic                          out_cell_filled,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [4:0]                    cfg_height
);
  import fsg_pkg::*;

  localparam int NSLOT = MAX_HEIGHT + 1;

  // configuration
  slot_t cfg_height_r;
  slot_t h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      cfg_height_r <= cfg_height;
    end
  end

  // height zero acts as one, anything above the maximum clamps
  always_comb begin
    if (cfg_height_r == '0) begin
      h_eff = slot_t'(1);
    end else if (cfg_height_r > slot_t'(MAX_HEIGHT)) begin
      h_eff = slot_t'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_r;
    end
  end

  // decode of the incoming key
  key_t                 key_in;
  logic [NUM_IDS-1:0]   pres_in;
  newid_t               fresh_in;
  slot_t                wcf_in;
  slot_t                nbv   [4];
  logic [3:0]           nben;
  slot_t                id1_in;
  logic                 nb0_in;
  logic                 nbm_in;

  assign key_in = {in_key_high, in_key_low};

  always_comb begin
    slot_t        mx;
    logic [5:0]   b;
    logic [5:0]   bs;
    logic         found;
    pres_in = '0;
    for (int k = 0; k < NSLOT; k++) begin
      if (5'(k) <= h_eff) pres_in[key_in[k*SLOT_BITS +: SLOT_BITS]] = 1'b1;
    end
    pres_in[0] = 1'b0;
    mx = '0;
    for (int x = 1; x < NUM_IDS; x++) begin
      if (pres_in[x]) mx = slot_t'(x);
    end
    fresh_in = {1'b0, mx} + newid_t'(1);
    b  = 6'($countones(pres_in));
    bs = (b > 6'd16) ? 6'd16 : b;
    wcf_in = 5'(6'd32 - bs);

    // neighbour slots in the order they are scanned
    nbv[0] = key_in[0 +: SLOT_BITS];
    nbv[1] = key_in[7'(h_eff - 5'd2) * 7'd5 +: SLOT_BITS];
    nbv[2] = key_in[7'(h_eff - 5'd1) * 7'd5 +: SLOT_BITS];
    nbv[3] = key_in[7'(h_eff) * 7'd5 +: SLOT_BITS];
    nben[0] = (in_row != '0);
    nben[1] = in_past_first_column && (({1'b0, in_row} + 6'd1) < {1'b0, h_eff});
    nben[2] = in_past_first_column;
    nben[3] = in_past_first_column && (in_row != '0);

    found  = 1'b0;
    id1_in = '0;
    for (int i = 0; i < 4; i++) begin
      if (nben[i] && nbv[i] != '0 && !found) begin
        found  = 1'b1;
        id1_in = nbv[i];
      end
    end
    nb0_in = !found;
    nbm_in = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (nben[i] && nbv[i] != '0 && nbv[i] != id1_in) nbm_in = 1'b1;
    end
  end

  // item register
  logic               item_v_r;
  key_t               key_r;
  logic [NUM_IDS-1:0] rem_r;
  newid_t             fresh_r;
  slot_t              wcf_r;
  slot_t              id1_r;
  logic               nb0_r;
  logic               nbm_r;
  logic [3:0]         joins_r;
  phase_t             phase_r, phase_nxt;

  // result register
  logic               out_valid_r;
  key_t               out_key_r;
  slot_t              out_wc_r;
  logic               out_q_r;
  logic               out_filled_r;
  logic               out_last_r;

  logic               out_free;
  logic               emit;
  logic               load;
  logic [NUM_IDS-1:0] low_oh;
  newid_t             low_id;
  newid_t             cur_id;
  logic               cur_last;
  slot_t              cur_wc;
  logic               cur_q;
  logic               cur_filled;
  key_t               succ_key;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = item_v_r && out_free;
  assign in_stall = item_v_r && !(out_free && cur_last);
  assign load     = in_valid && !in_stall;

  // lowest colour still to join
  assign low_oh = rem_r & (~rem_r + NUM_IDS'(1));
  always_comb begin
    low_id = '0;
    for (int x = 0; x < NUM_IDS; x++) begin
      if (low_oh[x]) low_id = newid_t'(x);
    end
  end

  // sequencer outputs
  always_comb begin
    cur_id     = '0;
    cur_last   = 1'b0;
    cur_wc     = slot_t'(1);
    cur_q      = 1'b0;
    cur_filled = 1'b1;
    case (phase_r)
      PH_EMPTY: begin
        cur_filled = 1'b0;
        cur_last   = nbm_r;
      end
      PH_ONE: begin
        cur_id   = {1'b0, id1_r};
        cur_last = 1'b1;
      end
      PH_JOIN: begin
        cur_id = low_id;
      end
      PH_FRESH: begin
        cur_id   = fresh_r;
        cur_wc   = wcf_r;
        cur_q    = 1'b1;
        cur_last = 1'b1;
      end
      default: begin
        cur_id = '0;
      end
    endcase
  end

  // sequencer next phase
  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = PH_EMPTY;
    end else if (emit) begin
      case (phase_r)
        PH_EMPTY: begin
          if (nbm_r) begin
            phase_nxt = PH_EMPTY;
          end else if (!nb0_r) begin
            phase_nxt = PH_ONE;
          end else if (rem_r != '0) begin
            phase_nxt = PH_JOIN;
          end else begin
            phase_nxt = PH_FRESH;
          end
        end
        PH_JOIN: begin
          if ((joins_r == MAX_JOINS - 4'd1) || ((rem_r & ~low_oh) == '0)) begin
            phase_nxt = PH_FRESH;
          end
        end
        default: phase_nxt = PH_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      phase_r  <= PH_EMPTY;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        item_v_r <= 1'b1;
      end else if (emit && cur_last) begin
        item_v_r <= 1'b0;
      end
    end
  end

  // item payload: load a new key, or drop the colour just joined
  always_ff @(posedge clk) begin
    if (load) begin
      key_r   <= key_in;
      rem_r   <= pres_in;
      fresh_r <= fresh_in;
      wcf_r   <= wcf_in;
      id1_r   <= id1_in;
      nb0_r   <= nb0_in;
      nbm_r   <= nbm_in;
      joins_r <= '0;
    end else if (emit && phase_r == PH_JOIN) begin
      rem_r   <= rem_r & ~low_oh;
      joins_r <= joins_r + 4'd1;
    end
  end

  fsg_relabel #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_relabel (
    .key     (key_r),
    .h       (h_eff),
    .newid   (cur_id),
    .key_out (succ_key)
  );

  // result register: advance when the slot is free, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_key_r    <= succ_key;
      out_wc_r     <= cur_wc;
      out_q_r      <= cur_q;
      out_filled_r <= cur_filled;
      out_last_r   <= cur_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_key_low    = out_key_r[LOW_BITS-1:0];
  assign out_next_key_high   = out_key_r[KEY_BITS-1:LOW_BITS];
  assign out_weight_constant = signed'(out_wc_r);
  assign out_weight_q        = out_q_r;
  assign out_cell_filled     = out_filled_r;
  assign out_last            = out_last_r;

endmodule

// ===== src/fsg_checker.sv =====
// Port-level checks for the frontier successor generator, bound to the top.
// Depends on fsg_pkg and frontier_successor_generator_core.
module fsg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fsg_pkg::LOW_BITS-1:0]  out_next_key_low,
  input logic signed [4:0]             out_weight_constant,
  input logic                          out_weight_q,
  input logic                          out_cell_filled,
  input logic                          out_last
);
  import fsg_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_next_key_low))
    else $error("stalled result key changed");

  a_empty_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cell_filled |-> !out_weight_q && out_weight_constant == 5'sd1)
    else $error("empty-cell beat has wrong weight");

  a_fresh_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_weight_q |-> out_last && out_cell_filled)
    else $error("fresh colour beat is not the final filled beat");

  a_join_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_weight_q |-> out_weight_constant == 5'sd1)
    else $error("non-fresh beat has weight other than one");

endmodule

bind frontier_successor_generator_core fsg_checker u_fsg_checker (.*);
